// ===== hw/rtl/prqs_pkg.sv =====
// prqs_pkg: sizes, codes, request/result structs and helper functions
// shared by the ready-queue scheduler modules. No dependencies.
package prqs_pkg;

  // Sizes of the scheduler.
  localparam int NumLevels = 256;
  localparam int MaxTasks  = 64;
  localparam int LvlW      = $clog2(NumLevels);
  localparam int TaskW     = $clog2(MaxTasks);

  // Fixed field widths of the request and result.
  localparam int TaskIdW = 6;
  localparam int PrioW   = 8;

  typedef enum logic [1:0] {
    FUNC_ENQ = 2'd0,
    FUNC_DEQ = 2'd1,
    FUNC_SEL = 2'd2
  } func_e;

  typedef struct packed {
    func_e              func;
    logic [TaskIdW-1:0] task_id;
    logic [PrioW-1:0]   prio;
  } req_t;

  typedef struct packed {
    logic [TaskIdW-1:0] next_task;
    logic               idle_selected;
    logic               switch_needed;
    logic               op_error;
  } rsp_t;

  // Write commands for the level head and tail tables.
  typedef struct packed {
    logic            we;
    logic [LvlW-1:0] addr;
    logic [TaskW-1:0] data;
  } lvl_wr_t;

  // Write commands for the per-task link tables.
  typedef struct packed {
    logic             we;
    logic [TaskW-1:0] addr;
    logic [TaskW-1:0] data;
  } link_wr_t;

  // Write command for the per-task level table.
  typedef struct packed {
    logic             we;
    logic [TaskW-1:0] addr;
    logic [LvlW-1:0]  data;
  } tlvl_wr_t;

  typedef struct packed {
    lvl_wr_t  head;
    lvl_wr_t  tail;
    link_wr_t nxt_link;
    link_wr_t prv_link;
    tlvl_wr_t task_lvl;
  } ram_wr_t;

  // Table contents fetched when a request is accepted.
  typedef struct packed {
    logic [LvlW-1:0]  task_lvl;
    logic [TaskW-1:0] prv_link;
    logic [TaskW-1:0] nxt_link;
    logic [TaskW-1:0] tail;
  } ram_rd_t;

  function automatic logic task_ok(logic [TaskIdW-1:0] id);
    return int'(id) < MaxTasks;
  endfunction

  function automatic logic [TaskW-1:0] task_idx(logic [TaskIdW-1:0] id);
    return TaskW'(id);
  endfunction

  // Levels past the top are saturated to the top level.
  function automatic logic [LvlW-1:0] level_idx(logic [PrioW-1:0] prio);
    if (int'(prio) >= NumLevels) begin
      return LvlW'(NumLevels - 1);
    end
    return LvlW'(prio);
  endfunction

endpackage

// ===== hw/rtl/prqs_ram.sv =====
// prqs_ram: generic single-write, single-read synchronous RAM with a
// registered, write-first read port. No package dependency.
module prqs_ram #(
  parameter int Depth = 2,
  parameter int Width = 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // A read of the address written in the same cycle returns the new data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/prqs_prio_enc.sv =====
// prqs_prio_enc: finds the highest set bit of the ready-level mask.
// Depends on prqs_pkg.
module prqs_prio_enc (
  input  logic [prqs_pkg::NumLevels-1:0] mask_i,
  output logic                           any_o,
  output logic [prqs_pkg::LvlW-1:0]      top_o
);
  import prqs_pkg::*;

  localparam int PadN = 1 << LvlW;

  logic [PadN-1:0] pad;
  logic            node_v  [LvlW+1][PadN];
  logic [LvlW-1:0] node_ix [LvlW+1][PadN];

  // Binary tree: at each level the upper half of a pair wins.
  always_comb begin
    pad     = PadN'(mask_i);
    node_v  = '{default: '0};
    node_ix = '{default: '0};
    for (int i = 0; i < PadN; i++) begin
      node_v[0][i]  = pad[i];
      node_ix[0][i] = LvlW'(i);
    end
    for (int l = 0; l < LvlW; l++) begin
      for (int j = 0; j < (PadN >> (l + 1)); j++) begin
        node_v[l+1][j]  = node_v[l][2*j+1] | node_v[l][2*j];
        node_ix[l+1][j] = node_v[l][2*j+1] ? node_ix[l][2*j+1] : node_ix[l][2*j];
      end
    end
  end

  assign any_o = node_v[LvlW][0];
  assign top_o = node_ix[LvlW][0];

endmodule

// ===== hw/rtl/prqs_list_ctrl.sv =====
// prqs_list_ctrl: per-level queue bookkeeping; holds the ready mask and the
// per-task flags and issues the table writes. Depends on prqs_pkg.
module prqs_list_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           commit_i,
  input  prqs_pkg::req_t                 req_i,
  input  prqs_pkg::ram_rd_t              rd_i,
  output prqs_pkg::ram_wr_t              wr_o,
  output logic [prqs_pkg::NumLevels-1:0] mask_o,
  output logic                           err_o
);
  import prqs_pkg::*;

  logic [NumLevels-1:0] mask_q, mask_d;
  logic [MaxTasks-1:0]  queued_q, queued_d;
  logic [MaxTasks-1:0]  has_prev_q, has_prev_d;
  logic [MaxTasks-1:0]  has_next_q, has_next_d;
  ram_wr_t              wr;
  logic [TaskW-1:0]     t;
  logic [LvlW-1:0]      p;
  logic                 t_ok, is_head, is_tail;

  // A task is the head of its level exactly when it has no predecessor,
  // and the tail when it has no successor.
  always_comb begin
    t          = task_idx(req_i.task_id);
    p          = level_idx(req_i.prio);
    t_ok       = task_ok(req_i.task_id);
    is_head    = !has_prev_q[t];
    is_tail    = !has_next_q[t];
    mask_d     = mask_q;
    queued_d   = queued_q;
    has_prev_d = has_prev_q;
    has_next_d = has_next_q;
    wr         = '0;
    err_o      = 1'b0;
    unique case (req_i.func)
      FUNC_ENQ: begin
        if (!t_ok || queued_q[t]) begin
          err_o = 1'b1;
        end else begin
          if (mask_q[p]) begin
            wr.nxt_link = '{we: 1'b1, addr: rd_i.tail, data: t};
            wr.prv_link = '{we: 1'b1, addr: t, data: rd_i.tail};
            has_next_d[rd_i.tail] = 1'b1;
            has_prev_d[t] = 1'b1;
          end else begin
            wr.head = '{we: 1'b1, addr: p, data: t};
            mask_d[p] = 1'b1;
            has_prev_d[t] = 1'b0;
          end
          wr.tail     = '{we: 1'b1, addr: p, data: t};
          wr.task_lvl = '{we: 1'b1, addr: t, data: p};
          has_next_d[t] = 1'b0;
          queued_d[t]   = 1'b1;
        end
      end
      FUNC_DEQ: begin
        if (!t_ok || !queued_q[t]) begin
          err_o = 1'b1;
        end else begin
          priority if (is_head && is_tail) begin
            mask_d[rd_i.task_lvl] = 1'b0;
          end else if (is_head) begin
            wr.head = '{we: 1'b1, addr: rd_i.task_lvl, data: rd_i.nxt_link};
            has_prev_d[rd_i.nxt_link] = 1'b0;
          end else if (is_tail) begin
            wr.tail = '{we: 1'b1, addr: rd_i.task_lvl, data: rd_i.prv_link};
            has_next_d[rd_i.prv_link] = 1'b0;
          end else begin
            wr.nxt_link = '{we: 1'b1, addr: rd_i.prv_link, data: rd_i.nxt_link};
            wr.prv_link = '{we: 1'b1, addr: rd_i.nxt_link, data: rd_i.prv_link};
          end
          queued_d[t] = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    wr_o             = wr;
    wr_o.head.we     = wr.head.we & commit_i;
    wr_o.tail.we     = wr.tail.we & commit_i;
    wr_o.nxt_link.we = wr.nxt_link.we & commit_i;
    wr_o.prv_link.we = wr.prv_link.we & commit_i;
    wr_o.task_lvl.we = wr.task_lvl.we & commit_i;
  end

  assign mask_o = mask_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q     <= '0;
      queued_q   <= '0;
      has_prev_q <= '0;
      has_next_q <= '0;
    end else if (commit_i) begin
      mask_q     <= mask_d;
      queued_q   <= queued_d;
      has_prev_q <= has_prev_d;
      has_next_q <= has_next_d;
    end
  end

endmodule

// ===== hw/rtl/priority_ready_queue_scheduler.sv =====
// priority_ready_queue_scheduler: top level of the bitmap ready-queue
// scheduler. Depends on prqs_pkg, prqs_ram, prqs_prio_enc, prqs_list_ctrl.
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+--------------------------
//   in      | to block  | in_valid_i/in_stall_o  | in_req_i  (func, task, prio)
//   out     | from block| out_valid_o/out_stall_i| out_rsp_o (head, idle, switch, error)
//
// One request is accepted every cycle while in_stall_o is low; its result
// passes through the queue stage into the result register. The table reads
// for a request are issued at acceptance, the list update and the mask encode
// run in the queue stage, and the head of the top level is read into the
// result register when that stage commits.
// Reset clears the ready mask, the queued flags and the running task (the
// idle task runs). The tables need no clearing: no entry is used before it is
// written. A stalled result holds the queue stage, which then stalls input.
module priority_ready_queue_scheduler (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  prqs_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output prqs_pkg::rsp_t out_rsp_o
);
  import prqs_pkg::*;

  // Queue stage: the accepted request, with its table data in the RAM
  // read registers.
  logic             s1_valid_q;
  req_t             s1_req_q;

  // Result stage: the head of the top level sits in the head RAM's read
  // register; the rest is held here.
  logic             out_valid_q;
  logic             out_sel_q, out_any_q, out_err_q;

  // Task that the last select handed to the processor.
  logic [TaskW-1:0] run_task_q;
  logic             run_idle_q;

  logic             accept, commit, out_take;
  logic [TaskW-1:0] in_t;
  logic [LvlW-1:0]  in_p;
  ram_rd_t          rd;
  ram_wr_t          wr;
  logic [NumLevels-1:0] mask_d;
  logic             any;
  logic [LvlW-1:0]  top_lvl;
  logic [TaskW-1:0] head;
  logic             err;

  // The queue stage moves on whenever the result register is free or is
  // being emptied in this cycle.
  assign commit     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;

  assign in_t = task_idx(in_req_i.task_id);
  assign in_p = level_idx(in_req_i.prio);

  // Per-level head table. It is read at the new top level while the update
  // is written, so a head written in the same cycle is forwarded.
  prqs_ram #(.Depth(NumLevels), .Width(TaskW)) u_head (
    .clk_i   (clk_i),
    .we_i    (wr.head.we),
    .waddr_i (wr.head.addr),
    .wdata_i (wr.head.data),
    .re_i    (commit),
    .raddr_i (top_lvl),
    .rdata_o (head)
  );

  // The remaining tables are read at acceptance at addresses taken from the
  // request; a write by the request ahead in the same cycle is forwarded.
  prqs_ram #(.Depth(NumLevels), .Width(TaskW)) u_tail (
    .clk_i   (clk_i),
    .we_i    (wr.tail.we),
    .waddr_i (wr.tail.addr),
    .wdata_i (wr.tail.data),
    .re_i    (accept),
    .raddr_i (in_p),
    .rdata_o (rd.tail)
  );

  prqs_ram #(.Depth(MaxTasks), .Width(TaskW)) u_nxt_link (
    .clk_i   (clk_i),
    .we_i    (wr.nxt_link.we),
    .waddr_i (wr.nxt_link.addr),
    .wdata_i (wr.nxt_link.data),
    .re_i    (accept),
    .raddr_i (in_t),
    .rdata_o (rd.nxt_link)
  );

  prqs_ram #(.Depth(MaxTasks), .Width(TaskW)) u_prv_link (
    .clk_i   (clk_i),
    .we_i    (wr.prv_link.we),
    .waddr_i (wr.prv_link.addr),
    .wdata_i (wr.prv_link.data),
    .re_i    (accept),
    .raddr_i (in_t),
    .rdata_o (rd.prv_link)
  );

  prqs_ram #(.Depth(MaxTasks), .Width(LvlW)) u_task_lvl (
    .clk_i   (clk_i),
    .we_i    (wr.task_lvl.we),
    .waddr_i (wr.task_lvl.addr),
    .wdata_i (wr.task_lvl.data),
    .re_i    (accept),
    .raddr_i (in_t),
    .rdata_o (rd.task_lvl)
  );

  // List update for the request in the queue stage.
  prqs_list_ctrl u_list_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (commit),
    .req_i    (s1_req_q),
    .rd_i     (rd),
    .wr_o     (wr),
    .mask_o   (mask_d),
    .err_o    (err)
  );

  // Highest non-empty level after this request.
  prqs_prio_enc u_prio_enc (
    .mask_i (mask_d),
    .any_o  (any),
    .top_o  (top_lvl)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (commit) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_req_q <= in_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_sel_q <= (s1_req_q.func == FUNC_SEL);
      out_any_q <= any;
      out_err_q <= err;
    end
  end

  // Results leave in order, so the running task is updated as a select's
  // result is taken; the next select compares against it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_task_q <= '0;
      run_idle_q <= 1'b1;
    end else if (out_take && out_sel_q) begin
      if (out_any_q) begin
        run_task_q <= head;
        run_idle_q <= 1'b0;
      end else begin
        run_task_q <= '0;
        run_idle_q <= 1'b1;
      end
    end
  end

  always_comb begin
    out_rsp_o.next_task     = out_any_q ? TaskIdW'(head) : '0;
    out_rsp_o.idle_selected = !out_any_q;
    out_rsp_o.op_error      = out_err_q;
    if (out_any_q) begin
      out_rsp_o.switch_needed = out_sel_q && (run_idle_q || (run_task_q != head));
    end else begin
      out_rsp_o.switch_needed = out_sel_q && !run_idle_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/prqs_checker.sv =====
// prqs_checker: port-level assertions for the ready-queue scheduler, bound
// to the top level. Depends on prqs_pkg and priority_ready_queue_scheduler.
module prqs_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input prqs_pkg::req_t in_req_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input prqs_pkg::rsp_t out_rsp_o
);

  // Input is only held off while a finished result waits to be taken.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("request stalled while the result side was free");

  // An accepted request moves through the queue stage into the result register
  // when the result side is free in the cycle after acceptance.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 (!out_valid_o || !out_stall_i) |=> out_valid_o)
    else $error("accepted request did not produce a result");

  // With no task ready the reported head is zero.
  a_idle_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.idle_selected) |-> (out_rsp_o.next_task == '0))
    else $error("idle result carries a task number");

  // Errors come only from enqueue or dequeue, switches only from select.
  a_err_sw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_rsp_o.op_error && out_rsp_o.switch_needed))
    else $error("result flags both an error and a switch");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_rsp_o)))
    else $error("stalled result dropped or changed");

endmodule

bind priority_ready_queue_scheduler prqs_checker u_prqs_checker (.*);
